// ===== rtl/rce_pkg.sv =====
// Shared types and constants for the reference-counted entry cache.
// No dependencies.
package rce_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int REF_W   = 16;
    localparam int VOL_W   = 4;
    localparam int NUM_W   = 32;
    localparam int TAG_W   = 1 + VOL_W + NUM_W;
    localparam int SLOT_W  = 6;
    localparam int STAT_W  = 3;

    localparam logic [REF_W-1:0] REF_MAX = '1;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FILLED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_LOADFAIL = 3'd3;
    localparam logic [STAT_W-1:0] ST_ZEROPUT  = 3'd4;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [VOL_W-1:0]  volume_id;
        logic [NUM_W-1:0]  object_number;
        logic [SLOT_W-1:0] release_slot;
        logic              load_ok;
    } in_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [REF_W-1:0]  ref_count;
        logic              went_free;
    } out_t;

endpackage

// ===== rtl/rce_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/refcounted_entry_cache_top.sv =====
// Top level: command FSM, tag scan and free-list update over four RAMs.
// Depends on rce_pkg and rce_ram.
// A put passes through read and update states before the registered done. A get
// scans the ENTRIES tags one per cycle from the tag RAM read port, then reads
// and updates the chosen entry; a full table ends the scan with ST_FULL.
// busy drops in the done cycle, so one command at a time.
// After reset a clearing pass over all ENTRIES entries initializes the RAMs;
// busy stays high meanwhile. The receiver cannot stall: done pulses one cycle.
module refcounted_entry_cache_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  rce_pkg::in_t cmd,
    output logic         done,
    output rce_pkg::out_t result
);
    import rce_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;

    localparam logic [1:0] K_HIT  = 2'd0;
    localparam logic [1:0] K_MISS = 2'd1;
    localparam logic [1:0] K_PUT  = 2'd2;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    logic [2:0]       state_reg, state_next;
    in_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0] tgt_reg, tgt_next;
    logic [1:0]       kind_reg, kind_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] fcnt_reg, fcnt_next;
    out_t             res_reg, res_next;
    logic             done_reg, done_next;

    logic             tag_we, refs_we, next_we, prev_we, rd_re;
    logic [IDX_W-1:0] tag_wa, refs_wa, next_wa, prev_wa, tag_ra;
    logic [TAG_W-1:0] tag_wd, tag_rd;
    logic [REF_W-1:0] refs_wd, refs_rd;
    logic [IDX_W-1:0] next_wd, prev_wd, next_rd, prev_rd;

    logic [IDX_W-1:0] cnt_idx;
    logic             tag_match;
    logic [REF_W-1:0] ref_inc, ref_dec;

    rce_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag_ram (
        .clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
        .re(1'b1), .raddr(tag_ra), .rdata(tag_rd)
    );
    rce_ram #(.WIDTH(REF_W), .DEPTH(ENTRIES)) u_refs_ram (
        .clk(clk), .we(refs_we), .waddr(refs_wa), .wdata(refs_wd),
        .re(rd_re), .raddr(tgt_reg), .rdata(refs_rd)
    );
    rce_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_next_ram (
        .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
        .re(rd_re), .raddr(tgt_reg), .rdata(next_rd)
    );
    rce_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_prev_ram (
        .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
        .re(rd_re), .raddr(tgt_reg), .rdata(prev_rd)
    );

    assign cnt_idx   = cnt_reg[IDX_W-1:0];
    assign tag_ra    = cnt_idx;
    assign tag_match = (tag_rd == {1'b1, cmd_reg.volume_id, cmd_reg.object_number});
    assign ref_inc   = (refs_rd == REF_MAX) ? REF_MAX : refs_rd + REF_W'(1);
    assign ref_dec   = refs_rd - REF_W'(1);
    assign rd_re     = (state_reg == S_READ);

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        cnt_next     = cnt_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        tgt_next     = tgt_reg;
        kind_next    = kind_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        fcnt_next    = fcnt_reg;
        res_next     = res_reg;
        done_next    = 1'b0;

        tag_we  = 1'b0;
        tag_wa  = tgt_reg;
        tag_wd  = '0;
        refs_we = 1'b0;
        refs_wa = tgt_reg;
        refs_wd = '0;
        next_we = 1'b0;
        next_wa = tgt_reg;
        next_wd = '0;
        prev_we = 1'b0;
        prev_wa = tgt_reg;
        prev_wd = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                tag_we  = 1'b1;
                tag_wa  = cnt_idx;
                refs_we = 1'b1;
                refs_wa = cnt_idx;
                next_we = 1'b1;
                next_wa = cnt_idx;
                next_wd = (cnt_idx == LAST) ? '0 : cnt_idx + IDX_W'(1);
                prev_we = 1'b1;
                prev_wa = cnt_idx;
                prev_wd = (cnt_idx == '0) ? LAST : cnt_idx - IDX_W'(1);
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_idx == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    cnt_next = '0;
                    if (cmd.mode == MODE_GET)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (32'(cmd.release_slot) >= ENTRIES)
                    begin
                        res_next  = '{status: ST_ZEROPUT, slot: cmd.release_slot,
                                      ref_count: '0, went_free: 1'b0};
                        done_next = 1'b1;
                    end
                    else
                    begin
                        tgt_next   = IDX_W'(cmd.release_slot);
                        kind_next  = K_PUT;
                        state_next = S_READ;
                    end
                end
            end
            S_SCAN:
            begin
                // tag read issued at cnt, compared in the next cycle
                if (cnt_reg < CNT_W'(ENTRIES))
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = cnt_idx;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                if (cmp_vld_reg && tag_match)
                begin
                    tgt_next   = cmp_idx_reg;
                    kind_next  = K_HIT;
                    state_next = S_READ;
                end
                else if (cmp_vld_reg && cmp_idx_reg == LAST)
                begin
                    if (fcnt_reg == '0)
                    begin
                        res_next   = '{status: ST_FULL, slot: '0,
                                       ref_count: '0, went_free: 1'b0};
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        tgt_next   = head_reg;
                        kind_next  = K_MISS;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                res_next   = '{status: ST_OK, slot: SLOT_W'(tgt_reg),
                               ref_count: '0, went_free: 1'b0};
                case (kind_reg) inside
                    K_HIT, K_MISS:
                    begin
                        // unlink from free list: hit on zero count, or fill
                        if ((kind_reg == K_MISS && cmd_reg.load_ok)
                            || (kind_reg == K_HIT && refs_rd == '0
                                && fcnt_reg != '0))
                        begin
                            if (tgt_reg == head_reg)
                            begin
                                head_next = next_rd;
                            end
                            else
                            begin
                                next_we = 1'b1;
                                next_wa = prev_rd;
                                next_wd = next_rd;
                            end
                            if (tgt_reg == tail_reg)
                            begin
                                tail_next = prev_rd;
                            end
                            else
                            begin
                                prev_we = 1'b1;
                                prev_wa = next_rd;
                                prev_wd = prev_rd;
                            end
                            fcnt_next = fcnt_reg - CNT_W'(1);
                        end
                        refs_we = 1'b1;
                        if (kind_reg == K_HIT)
                        begin
                            refs_wd            = ref_inc;
                            res_next.ref_count = ref_inc;
                        end
                        else
                        begin
                            // failed load leaves the entry at the list head
                            tag_we = 1'b1;
                            if (cmd_reg.load_ok)
                            begin
                                tag_wd = {1'b1, cmd_reg.volume_id,
                                          cmd_reg.object_number};
                                refs_wd            = REF_W'(1);
                                res_next.ref_count = REF_W'(1);
                                res_next.status    = ST_FILLED;
                            end
                            else
                            begin
                                res_next.status = ST_LOADFAIL;
                            end
                        end
                    end
                    default:
                    begin
                        res_next.slot = cmd_reg.release_slot;
                        if (refs_rd == '0)
                        begin
                            res_next.status = ST_ZEROPUT;
                        end
                        else
                        begin
                            refs_we            = 1'b1;
                            refs_wd            = ref_dec;
                            res_next.ref_count = ref_dec;
                            if (ref_dec == '0)
                            begin
                                res_next.went_free = 1'b1;
                                if (fcnt_reg == '0)
                                begin
                                    head_next = tgt_reg;
                                end
                                else
                                begin
                                    next_we = 1'b1;
                                    next_wa = tail_reg;
                                    next_wd = tgt_reg;
                                    prev_we = 1'b1;
                                    prev_wa = tgt_reg;
                                    prev_wd = tail_reg;
                                end
                                tail_next = tgt_reg;
                                fcnt_next = fcnt_reg + CNT_W'(1);
                            end
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= LAST;
            fcnt_reg    <= CNT_W'(ENTRIES);
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cmp_vld_reg <= cmp_vld_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            fcnt_reg    <= fcnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        cmp_idx_reg <= cmp_idx_next;
        tgt_reg     <= tgt_next;
        kind_reg    <= kind_next;
        res_reg     <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= CNT_W'(ENTRIES))
        else $error("free count above table size");
    a_start_reacts: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted word produced no activity");
    a_went_free: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.went_free |-> result.status == ST_OK && result.ref_count == '0)
        else $error("went_free with nonzero count");
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_FULL |-> fcnt_reg == '0)
        else $error("table full reported with free entries");

endmodule
